>>> src/z85_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// z85 stream decoder assertion macros
// Concurrent assertion forms used by the decoder job queue.
// ----------------------------------------------------------------------------
`ifndef Z85_STREAM_DECODER_MACROS_SVH
`define Z85_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define Z85_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("z85 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define Z85_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("z85 assertion failed");

`endif

>>> src/z85_pkg.sv
// ----------------------------------------------------------------------------
// z85 package
// Item types, alphabet table and padding constants for the Z85 decoder.
// ----------------------------------------------------------------------------
package z85_pkg;

    localparam int RADIX       = 85;
    localparam int QUEUE_DEPTH = 4;
    localparam int GROUP_LEN   = 5;

    // Padding a group of c characters with the top digit gives
    // (acc + 1) * 85^(5-c) - 1, i.e. acc * P + (P - 1).
    localparam logic [31:0] PAD_MUL_C2 = 32'd614125;
    localparam logic [31:0] PAD_MUL_C3 = 32'd7225;
    localparam logic [31:0] PAD_MUL_C4 = 32'd85;
    localparam logic [31:0] PAD_MUL_FULL = 32'd1;

    localparam logic [7:0] ALPHABET [RADIX] = '{
        "0","1","2","3","4","5","6","7","8","9",
        "a","b","c","d","e","f","g","h","i","j","k","l","m",
        "n","o","p","q","r","s","t","u","v","w","x","y","z",
        "A","B","C","D","E","F","G","H","I","J","K","L","M",
        "N","O","P","Q","R","S","T","U","V","W","X","Y","Z",
        ".","-",":","+","=","^","!","/","*","?","&","<",">",
        "(",")","[","]","{","}","@","%","$","#"
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       no_data;
        logic       bad_char;
        logic       final_res;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [6:0] digit;
    } t_digit;

    // One queued job: a finished or closing group, or an error marker.
    typedef struct packed {
        logic [31:0] acc;
        logic [2:0]  cnt;
        logic        last;
        logic        bad;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_digit z85_digit(input logic [7:0] ch);
        t_digit r;
        r = '0;
        for (int i = 0; i < RADIX; i++) begin
            if (ALPHABET[i] == ch) begin
                r.valid = 1'b1;
                r.digit = 7'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> src/z85_front.sv
// ----------------------------------------------------------------------------
// z85 front end
// Accepts characters, maps them to digits, builds groups and queues jobs.
// ----------------------------------------------------------------------------
module z85_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  z85_pkg::t_in_item   i_in_item,
    input  z85_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output z85_pkg::t_job       o_job
);

    logic [31:0]      r_acc, n_acc;
    logic [2:0]       r_cnt, n_cnt;
    logic             r_drain, n_drain;
    logic             accept;
    z85_pkg::t_digit  dig;
    logic [31:0]      acc_new;
    logic [2:0]       cnt_new;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign dig        = z85_pkg::z85_digit(i_in_item.char_code);

    // acc * 85 as shifts and adds
    assign acc_new = (r_acc << 6) + (r_acc << 4) + (r_acc << 2) + r_acc
                   + {25'd0, dig.digit};
    assign cnt_new = r_cnt + 3'd1;

    always_comb begin
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_drain = r_drain;
        o_push  = 1'b0;
        o_job   = '0;
        if (accept) begin
            if (r_drain) begin
                if (i_in_item.end_of_text) begin
                    n_drain = 1'b0;
                    n_acc   = '0;
                    n_cnt   = '0;
                end
            end else if (!dig.valid) begin
                o_push    = 1'b1;
                o_job.bad = 1'b1;
                o_job.last = 1'b1;
                n_acc     = '0;
                n_cnt     = '0;
                n_drain   = !i_in_item.end_of_text;
            end else if (cnt_new == 3'(z85_pkg::GROUP_LEN) || i_in_item.end_of_text) begin
                o_push     = 1'b1;
                o_job.acc  = acc_new;
                o_job.cnt  = cnt_new;
                o_job.last = i_in_item.end_of_text;
                n_acc      = '0;
                n_cnt      = '0;
            end else begin
                n_acc = acc_new;
                n_cnt = cnt_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_cnt   <= '0;
            r_drain <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_drain <= n_drain;
        end
    end

endmodule

>>> src/z85_queue.sv
// ----------------------------------------------------------------------------
// z85 job queue
// Short FIFO that decouples the front end from the byte emitter.
// ----------------------------------------------------------------------------
`include "z85_stream_decoder_macros.svh"

module z85_queue #(
    parameter int DEPTH = z85_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  z85_pkg::t_job       i_job,
    input  logic                i_pop,
    output z85_pkg::t_job       o_head,
    output z85_pkg::t_q_status  o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    z85_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `Z85_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_status.full)
    `Z85_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_status.empty)
    `Z85_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)
    `Z85_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, i_pop && !i_push, r_count == $past(r_count) - 1'b1)

endmodule

>>> src/z85_back.sv
// ----------------------------------------------------------------------------
// z85 back end
// Pads closing groups and emits decoded bytes, most significant first.
// ----------------------------------------------------------------------------
module z85_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  z85_pkg::t_job       i_head,
    input  z85_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output z85_pkg::t_out_item  o_out_item
);

    logic        r_busy;
    logic [31:0] r_val;
    logic [2:0]  r_left;
    logic        r_marker;
    logic        r_bad;
    logic        r_fin;

    logic        out_accept;
    logic        last_byte;
    logic [31:0] pad_mul;
    logic [31:0] padded;

    assign out_accept = r_busy && !i_out_stall;
    assign last_byte  = (r_left == 3'd1);
    assign o_pop      = !i_q_status.empty && (!r_busy || (out_accept && last_byte));

    always_comb begin
        case (i_head.cnt)
            3'd2:    pad_mul = z85_pkg::PAD_MUL_C2;
            3'd3:    pad_mul = z85_pkg::PAD_MUL_C3;
            3'd4:    pad_mul = z85_pkg::PAD_MUL_C4;
            default: pad_mul = z85_pkg::PAD_MUL_FULL;
        endcase
    end

    // acc * P + (P - 1) wraps mod 2^32; a full group passes through as is
    assign padded = i_head.acc * pad_mul + (pad_mul - 32'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (out_accept && last_byte) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_val <= padded;
            if (i_head.bad || i_head.cnt == 3'd1) begin
                r_marker <= 1'b1;
                r_bad    <= i_head.bad;
                r_left   <= 3'd1;
                r_fin    <= 1'b1;
            end else if (i_head.cnt == 3'(z85_pkg::GROUP_LEN)) begin
                r_marker <= 1'b0;
                r_bad    <= 1'b0;
                r_left   <= 3'd4;
                r_fin    <= i_head.last;
            end else begin
                r_marker <= 1'b0;
                r_bad    <= 1'b0;
                r_left   <= i_head.cnt - 3'd1;
                r_fin    <= 1'b1;
            end
        end else if (out_accept) begin
            // advance to the next byte of the word
            r_val  <= r_val << 8;
            r_left <= r_left - 3'd1;
        end
    end

    assign o_out_valid          = r_busy;
    assign o_out_item.data_byte = r_marker ? 8'd0 : r_val[31:24];
    assign o_out_item.no_data   = r_marker;
    assign o_out_item.bad_char  = r_bad;
    assign o_out_item.final_res = r_fin && last_byte;

endmodule

>>> src/z85_stream_decoder.sv
// ----------------------------------------------------------------------------
// z85 stream decoder: the queue registers each job and the back end registers its
// padded word before the first byte. One character per cycle in while the queue has
// room, one byte per cycle out unless stalled; a 4-deep queue (default) absorbs bursts.
// Reset: synchronous active low, clears group state, queue and emitter at once.
// ----------------------------------------------------------------------------
module z85_stream_decoder #(
    parameter int QUEUE_DEPTH = z85_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  z85_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output z85_pkg::t_out_item  o_out_item
);

    z85_pkg::t_q_status q_status;
    z85_pkg::t_job      push_job;
    z85_pkg::t_job      head_job;
    logic               push;
    logic               pop;

    z85_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    z85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    z85_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
